// ===== hw/rtl/efg_pkg.sv =====
package efg_pkg;

   localparam int TASK_W  = 8;
   localparam int TYPE_W  = 3;
   localparam int WORD_W  = 32;
   localparam int ENTRY_W = TASK_W + TYPE_W + WORD_W;
   localparam int COUNT_W = 4;

   localparam int WT_SET_BIT     = 0;
   localparam int WT_ALL_BIT     = 1;
   localparam int WT_CONSUME_BIT = 2;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'd0,
      MODE_GET     = 3'd1,
      MODE_SET     = 3'd2,
      MODE_CLEAR   = 3'd3,
      MODE_DESTROY = 3'd4,
      MODE_INIT    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_REPLY   = 2'd0,
      KIND_WAKE    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNAVAIL = 3'd1,
      ST_DELETED = 3'd2,
      ST_FULL    = 3'd3,
      ST_QUEUED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_EXEC    = 2'd1,
      S_WALK    = 2'd2,
      S_SUMMARY = 2'd3
   } state_type;

endpackage

// ===== hw/rtl/efg_check.sv =====
module efg_check
   import efg_pkg::*;
#(
   parameter int FLAG_BITS = 32
) (
   input  logic [FLAG_BITS-1:0] flags,
   input  logic [FLAG_BITS-1:0] req_flags,
   input  logic [TYPE_W-1:0]    wait_type,
   output logic [FLAG_BITS-1:0] matched,
   output logic                 satisfied,
   output logic [FLAG_BITS-1:0] flags_next
);

   logic set_test;
   logic all_test;
   logic consume;

   assign set_test = wait_type[WT_SET_BIT];
   assign all_test = wait_type[WT_ALL_BIT];
   assign consume  = wait_type[WT_CONSUME_BIT];

   always_comb begin
      matched   = set_test ? (flags & req_flags) : (~flags & req_flags);
      satisfied = all_test ? (matched == req_flags) : (matched != '0);
      flags_next = flags;
      if (satisfied && consume) begin
         flags_next = set_test ? (flags & ~req_flags) : (flags | req_flags);
      end
   end

endmodule

// ===== hw/rtl/event_flag_group_with_waiters.sv =====
// event flag group with an arrival-ordered waiter table
//
// req channel: one item per request (wait, get, notify set/clear, destroy,
// initialize). req_ready is high only while the block is idle; one item is
// handled at a time. csr channel: always ready, loads the init flag value.
// rsp channel: each item gives zero or more reply/wake items and always ends
// with one summary item carrying last = 1, the flag word and waiter count.
//
// item flow, with rsp_ready held high: wait, get, initialize and the unused
// codes pass from accept through execute to the summary; notify and destroy
// also walk the queued waiters in between, one entry per cycle with the
// flag word updated between entries; the waiter table is a synchronous
// memory with one read and one write port. results pass through one output
// register; while it holds an item and rsp_ready is low, no item is emitted
// and the walk pauses on an entry to wake or delete but still compacts the
// rest. reset (synchronous, active high) clears the flag word, the waiter
// count, init register and output valid bit; table contents need no clear.
module event_flag_group_with_waiters
   import efg_pkg::*;
#(
   parameter int FLAG_BITS = 32,
   parameter int WAITERS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [TASK_W-1:0]  req_task_id,
   input  logic [TYPE_W-1:0]  req_wait_type,
   input  logic [WORD_W-1:0]  req_request_flags,
   input  logic [WORD_W-1:0]  req_notify_flags,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [TASK_W-1:0]  rsp_task_id_res,
   output logic [2:0]         rsp_status,
   output logic [WORD_W-1:0]  rsp_result_flags,
   output logic [WORD_W-1:0]  rsp_current_flags,
   output logic [COUNT_W-1:0] rsp_waiter_count,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [WORD_W-1:0]  csr_init_flags
);

   localparam int CW = $clog2(WAITERS + 1);
   localparam int AW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam logic [CW-1:0] WAITERS_C = CW'(WAITERS);

   state_type state_ff, state_in;

   logic [WORD_W-1:0]  init_ff;
   logic [FLAG_BITS-1:0] flag_ff, flag_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      keep_ff, keep_in;

   logic [2:0]         item_mode_ff;
   logic [TASK_W-1:0]  item_task_ff;
   logic [TYPE_W-1:0]  item_type_ff;
   logic [WORD_W-1:0]  item_req_ff;
   logic [WORD_W-1:0]  item_notify_ff;

   logic [ENTRY_W-1:0] mem [WAITERS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [TASK_W-1:0]  rsp_task_ff;
   status_type         rsp_status_ff;
   logic [WORD_W-1:0]  rsp_result_ff;
   logic [WORD_W-1:0]  rsp_current_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   logic               emit;
   kind_type           o_kind;
   logic [TASK_W-1:0]  o_task;
   status_type         o_status;
   logic [WORD_W-1:0]  o_result;
   logic [WORD_W-1:0]  o_current;
   logic [COUNT_W-1:0] o_count;
   logic               o_last;

   logic               can_emit;
   logic               req_accept;

   // entry fields
   logic [TASK_W-1:0]  ent_task;
   logic [TYPE_W-1:0]  ent_type;
   logic [WORD_W-1:0]  ent_req;

   // width fitting between 32-bit fields and the flag word
   logic [FLAG_BITS+WORD_W-1:0] item_req_ext, ent_req_ext, notify_ext, init_ext;
   logic [FLAG_BITS-1:0] item_req_fit, ent_req_fit, notify_fit, init_fit;
   logic [FLAG_BITS+WORD_W-1:0] matched_ext, flag_ext;
   logic [WORD_W-1:0]  matched_word, flag_word_out;
   logic [CW+COUNT_W-1:0] count_ext;

   logic [TYPE_W-1:0]    chk_type;
   logic [FLAG_BITS-1:0] chk_req;
   logic [FLAG_BITS-1:0] chk_matched;
   logic                 chk_ok;
   logic [FLAG_BITS-1:0] chk_next;

   logic               is_destroy;
   logic               walk_adv;
   logic               walk_more;
   logic [CW-1:0]      idx_next;

   assign {ent_task, ent_type, ent_req} = rd_data_ff;

   assign item_req_ext = {{FLAG_BITS{1'b0}}, item_req_ff};
   assign ent_req_ext  = {{FLAG_BITS{1'b0}}, ent_req};
   assign notify_ext   = {{FLAG_BITS{1'b0}}, item_notify_ff};
   assign init_ext     = {{FLAG_BITS{1'b0}}, init_ff};
   assign item_req_fit = item_req_ext[FLAG_BITS-1:0];
   assign ent_req_fit  = ent_req_ext[FLAG_BITS-1:0];
   assign notify_fit   = notify_ext[FLAG_BITS-1:0];
   assign init_fit     = init_ext[FLAG_BITS-1:0];

   assign matched_ext   = {{WORD_W{1'b0}}, chk_matched};
   assign matched_word  = matched_ext[WORD_W-1:0];
   assign flag_ext      = {{WORD_W{1'b0}}, flag_ff};
   assign flag_word_out = flag_ext[WORD_W-1:0];
   assign count_ext     = {{COUNT_W{1'b0}}, total_ff};

   efg_check #(
      .FLAG_BITS(FLAG_BITS)
   ) u_check (
      .flags     (flag_ff),
      .req_flags (chk_req),
      .wait_type (chk_type),
      .matched   (chk_matched),
      .satisfied (chk_ok),
      .flags_next(chk_next)
   );

   assign can_emit   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign is_destroy = (item_mode_ff == MODE_DESTROY);
   assign walk_adv   = !(is_destroy || chk_ok) || can_emit;
   assign idx_next   = idx_ff + CW'(1);
   assign walk_more  = (idx_next < total_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (item_mode_ff)
               MODE_WAIT, MODE_GET: begin
                  if (can_emit) state_in = S_SUMMARY;
               end
               MODE_SET, MODE_CLEAR, MODE_DESTROY: begin
                  state_in = (total_ff != '0) ? S_WALK : S_SUMMARY;
               end
               default: state_in = S_SUMMARY;
            endcase
         end
         S_WALK: begin
            if (walk_adv && !walk_more) state_in = S_SUMMARY;
         end
         S_SUMMARY: begin
            if (can_emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control and result selection
   always_comb begin
      emit      = 1'b0;
      o_kind    = KIND_SUMMARY;
      o_task    = '0;
      o_status  = ST_OK;
      o_result  = '0;
      o_current = '0;
      o_count   = '0;
      o_last    = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = total_ff[AW-1:0];
      wr_data   = {item_task_ff, item_type_ff, item_req_ff};
      flag_in   = flag_ff;
      total_in  = total_ff;
      keep_in   = keep_ff;
      idx_in    = idx_ff;
      chk_type  = item_type_ff;
      chk_req   = item_req_fit;
      case (state_ff)
         S_EXEC: begin
            case (item_mode_ff)
               MODE_WAIT, MODE_GET: begin
                  if (can_emit) begin
                     emit     = 1'b1;
                     o_kind   = KIND_REPLY;
                     o_task   = item_task_ff;
                     o_result = matched_word;
                     flag_in  = chk_next;
                     if (chk_ok) begin
                        o_status = ST_OK;
                     end else if (item_mode_ff == MODE_GET) begin
                        o_status = ST_UNAVAIL;
                     end else if (total_ff == WAITERS_C) begin
                        o_status = ST_FULL;
                     end else begin
                        o_status = ST_QUEUED;
                        wr_en    = 1'b1;
                        total_in = total_ff + CW'(1);
                     end
                  end
               end
               MODE_SET, MODE_CLEAR, MODE_DESTROY: begin
                  if (item_mode_ff == MODE_SET) begin
                     flag_in = flag_ff | notify_fit;
                  end else if (item_mode_ff == MODE_CLEAR) begin
                     flag_in = flag_ff & ~notify_fit;
                  end
                  idx_in  = '0;
                  keep_in = '0;
                  rd_en   = (total_ff != '0);
               end
               MODE_INIT: begin
                  flag_in  = init_fit;
                  total_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            chk_type = ent_type;
            chk_req  = ent_req_fit;
            if (is_destroy) begin
               emit     = can_emit;
               o_kind   = KIND_WAKE;
               o_task   = ent_task;
               o_status = ST_DELETED;
               o_result = ent_req;
            end else if (chk_ok) begin
               emit     = can_emit;
               o_kind   = KIND_WAKE;
               o_task   = ent_task;
               o_status = ST_OK;
               o_result = matched_word;
               if (can_emit) flag_in = chk_next;
            end else begin
               // still waiting: compact toward the head
               wr_en   = 1'b1;
               wr_addr = keep_ff[AW-1:0];
               wr_data = rd_data_ff;
               keep_in = keep_ff + CW'(1);
            end
            if (walk_adv) begin
               idx_in = idx_next;
               if (walk_more) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_next[AW-1:0];
               end else begin
                  total_in = is_destroy ? '0 : keep_in;
               end
            end
         end
         S_SUMMARY: begin
            emit      = can_emit;
            o_kind    = KIND_SUMMARY;
            o_current = flag_word_out;
            o_count   = count_ext[COUNT_W-1:0];
            o_last    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // waiter table
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         init_ff  <= '0;
         flag_ff  <= '0;
         total_ff <= '0;
         idx_ff   <= '0;
         keep_ff  <= '0;
      end else begin
         state_ff <= state_in;
         flag_ff  <= flag_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
         keep_ff  <= keep_in;
         if (csr_valid && csr_ready) init_ff <= csr_init_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_mode_ff   <= req_mode;
         item_task_ff   <= req_task_id;
         item_type_ff   <= req_wait_type;
         item_req_ff    <= req_request_flags;
         item_notify_ff <= req_notify_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= o_kind;
         rsp_task_ff    <= o_task;
         rsp_status_ff  <= o_status;
         rsp_result_ff  <= o_result;
         rsp_current_ff <= o_current;
         rsp_count_ff   <= o_count;
         rsp_last_ff    <= o_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_task_id_res   = rsp_task_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_flags  = rsp_result_ff;
   assign rsp_current_flags = rsp_current_ff;
   assign rsp_waiter_count  = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= WAITERS_C)
      else $error("waiter count above table depth");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> idx_ff < total_ff)
      else $error("walk index beyond waiter count");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> keep_ff <= idx_ff)
      else $error("compaction write overtakes walk read");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EXEC && !req_ready)
      else $error("accepted item not taken into execution");

   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      emit && o_last |-> state_ff == S_SUMMARY && o_kind == KIND_SUMMARY)
      else $error("last flag outside summary");

endmodule
